[hdl/ougn_pkg.sv]
// ----------------------------------------------------------------------------
// ougn_pkg
// Types and constants of the Ornstein-Uhlenbeck phase noise generator.
// ----------------------------------------------------------------------------
package ougn_pkg;

  // Payload of one input item and one result item
  typedef struct packed {
    logic       command;
    logic [9:0] phase_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] phase_value;
    logic [9:0]         phase_index_out;
  } out_item_t;

  // Commands
  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] REG_RNG_SEED       = 8'd0;
  localparam logic [7:0] REG_NOISE_VARIANCE = 8'd1;
  localparam logic [7:0] REG_DAMPING_FACTOR = 8'd2;
  localparam logic [7:0] REG_DRIVING_SCALE  = 8'd3;

  // Generator and fixed-point constants
  localparam logic [30:0] PM_MOD     = 31'd2147483647;
  localparam logic [14:0] PM_MUL     = 15'd16807;
  localparam logic [30:0] UNI_MAX    = 31'd2147483390;
  localparam logic [30:0] LN2X2_Q30  = 31'd1488522236;
  localparam logic [30:0] PI_Q29     = 31'd1686629713;
  localparam logic [30:0] ONE_Q30    = 31'd1073741824;
  localparam logic [29:0] QTR_TURN   = 30'd536870912;

  // Loop lengths
  localparam logic [4:0] NORM_LAST  = 5'd4;
  localparam logic [4:0] LOG_LAST   = 5'd23;
  localparam logic [4:0] SQRT_LAST  = 5'd27;
  localparam logic [2:0] TERM_LAST  = 3'd6;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW1,
    S_DRAW2,
    S_NORM,
    S_LOG,
    S_LNMUL,
    S_SQRT,
    S_XMUL,
    S_X2,
    S_TMUL,
    S_TDIV,
    S_TFIX,
    S_GMUL,
    S_SCALE,
    S_DRIVE,
    S_DONE
  } state_e;

  // Taylor divisor (2k+1)(2k+2)
  function automatic logic [7:0] term_div(input logic [2:0] k);
    logic [7:0] d;
    unique case (k)
      3'd0:    d = 8'd2;
      3'd1:    d = 8'd12;
      3'd2:    d = 8'd30;
      3'd3:    d = 8'd56;
      3'd4:    d = 8'd90;
      3'd5:    d = 8'd132;
      3'd6:    d = 8'd182;
      default: d = 8'd182;
    endcase
    return d;
  endfunction

  // floor(2^33 / divisor), quotient estimate is low by at most one
  function automatic logic [32:0] term_recip(input logic [2:0] k);
    logic [32:0] r;
    unique case (k)
      3'd0:    r = 33'd4294967296;
      3'd1:    r = 33'd715827882;
      3'd2:    r = 33'd286331153;
      3'd3:    r = 33'd153391689;
      3'd4:    r = 33'd95443717;
      3'd5:    r = 33'd65075262;
      3'd6:    r = 33'd47197442;
      default: r = 33'd47197442;
    endcase
    return r;
  endfunction

endpackage

[hdl/ou_gaussian_noise_generator_core.sv]
// ----------------------------------------------------------------------------
// ou_gaussian_noise_generator_core
// Ornstein-Uhlenbeck phase generator driven by fixed-point Box-Muller noise.
// ----------------------------------------------------------------------------
// An item runs through the sequencer from acceptance to result; an update
// adds a state for its extra driving product. The steps are two generator draws,
// a 5-step normalize, 24 squaring steps for the log, one log scaling product,
// 28 square-root digit steps, two cosine argument products, seven Taylor terms
// of a product, a reciprocal product and a correction each, the Gaussian
// product and one or two scaling products. All products go through one shared
// 33x33 multiplier. The block takes one item at a time, and the next item is
// accepted in the cycle after the result is loaded. The result is held in an
// output register, so a new item is taken while the last result waits. A
// stalled earlier result holds the finished item in the sequencer until it leaves.
// Phase entries live in a memory of PHASE_ENTRIES words; an entry must be
// initialized before it is updated.
module ou_gaussian_noise_generator_core
  import ougn_pkg::*;
#(
  parameter int unsigned PHASE_ENTRIES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(PHASE_ENTRIES);

  // Control state
  state_e      state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [2:0]  k_q;
  logic [30:0] seed_q;
  logic [30:0] nv_q;
  logic [31:0] damp_q;
  logic [30:0] ds_q;
  logic        out_valid_q;

  // Datapath registers
  logic        cmd_q;
  logic [9:0]  idx_q;
  logic        inside_q;
  logic [31:0] rd_q;
  logic [30:0] y_q;
  logic [4:0]  lz_q;
  logic [23:0] f_q;
  logic [30:0] u2_q;
  logic [55:0] v_q, res_q, bit_q;
  logic [30:0] x_q;
  logic [31:0] x2_q;
  logic [31:0] mag_q;
  logic [32:0] ta_q;
  logic [31:0] q0_q;
  logic signed [34:0] sum_q;
  logic [26:0] gmag_q;
  logic        gneg_q;
  logic signed [35:0] term_a_q, term_b_q;
  out_item_t   out_q;

  logic [31:0] mem [PHASE_ENTRIES];

  // Shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;

  assign prod = 66'(mul_a) * 66'(mul_b);

  // Generator step: 16807*s mod (2^31-1) by folding the high part
  logic [30:0] seed_use;
  logic [31:0] pm_fold;
  logic [30:0] pm_next;
  logic [30:0] uni;

  assign seed_use = (seed_q == 31'd0 || seed_q == PM_MOD) ? 31'd1 : seed_q;
  assign pm_fold  = 32'(prod[30:0]) + 32'(prod[45:31]);
  assign pm_next  = (pm_fold >= 32'(PM_MOD)) ? 31'(pm_fold - 32'(PM_MOD))
                                             : pm_fold[30:0];
  assign uni      = (pm_next < UNI_MAX) ? pm_next : UNI_MAX;

  // Normalize step: shift by 16, 8, 4, 2, 1
  logic [4:0]  shamt;
  logic        top_zero;

  assign shamt    = 5'd16 >> cnt_q;
  assign top_zero = (y_q >> (5'd31 - shamt)) == 31'd0;

  // Log square step and its fraction bit
  logic [31:0] sq;
  logic [28:0] n_val;

  assign sq    = prod[61:30];
  assign n_val = {5'(lz_q + 5'd1), 24'd0} - 29'(f_q);

  // Square-root digit step
  logic [55:0] trial;
  logic        take;

  assign trial = res_q + bit_q;
  assign take  = v_q >= trial;

  // Cosine argument
  logic [1:0]  quad;
  logic [29:0] rr;

  assign quad = u2_q[30:29];
  assign rr   = quad[0] ? (QTR_TURN - 30'(u2_q[28:0])) : 30'(u2_q[28:0]);

  // Taylor term correction
  logic [7:0]  dvs;
  logic [40:0] qd, rem;
  logic [31:0] term_q;

  assign dvs    = term_div(k_q);
  assign qd     = 41'(q0_q) * 41'(dvs);
  assign rem    = 41'(ta_q) - qd;
  assign term_q = (rem >= 41'(dvs)) ? q0_q + 32'd1 : q0_q;

  // Clamped cosine magnitude and sign
  logic [30:0] cmag;
  logic        cneg;

  always_comb begin
    if (sum_q < 35'sd0) begin
      cmag = 31'd0;
    end else if (sum_q > 35'sd1073741824) begin
      cmag = ONE_Q30;
    end else begin
      cmag = sum_q[30:0];
    end
  end

  assign cneg = (quad == 2'd1 || quad == 2'd2) && (cmag != 31'd0);

  // Old entry magnitude
  logic [31:0] old_val, omag;
  logic        oneg;

  assign old_val = inside_q ? rd_q : 32'd0;
  assign oneg    = old_val[31];
  assign omag    = oneg ? (~old_val + 32'd1) : old_val;

  // Final sum and saturation
  logic signed [35:0] val;
  logic [31:0]        sat_val;

  assign val = term_a_q + term_b_q;

  always_comb begin
    if (val > 36'sd2147483647) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (val < -36'sd2147483648) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = val[31:0];
    end
  end

  logic out_free;
  logic in_acc;
  logic cnt_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign cnt_last = (state_q == S_NORM && cnt_q == NORM_LAST) ||
                    (state_q == S_LOG  && cnt_q == LOG_LAST)  ||
                    (state_q == S_SQRT && cnt_q == SQRT_LAST);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DRAW1;
      S_DRAW1: state_d = S_DRAW2;
      S_DRAW2: state_d = S_NORM;
      S_NORM:  if (cnt_last) state_d = S_LOG;
      S_LOG:   if (cnt_last) state_d = S_LNMUL;
      S_LNMUL: state_d = S_SQRT;
      S_SQRT:  if (cnt_last) state_d = S_XMUL;
      S_XMUL:  state_d = S_X2;
      S_X2:    state_d = S_TMUL;
      S_TMUL:  state_d = S_TDIV;
      S_TDIV:  state_d = S_TFIX;
      S_TFIX:  state_d = (k_q == TERM_LAST) ? S_GMUL : S_TMUL;
      S_GMUL:  state_d = S_SCALE;
      S_SCALE: state_d = (cmd_q == CMD_UPDATE) ? S_DRIVE : S_DONE;
      S_DRIVE: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: stall and multiplier operands
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    mul_a      = 33'd0;
    mul_b      = 33'd0;
    unique case (state_q)
      S_DRAW1, S_DRAW2: begin
        mul_a = 33'(seed_use);
        mul_b = 33'(PM_MUL);
      end
      S_LOG: begin
        mul_a = 33'(y_q);
        mul_b = 33'(y_q);
      end
      S_LNMUL: begin
        mul_a = 33'(n_val);
        mul_b = 33'(LN2X2_Q30);
      end
      S_XMUL: begin
        mul_a = 33'(rr);
        mul_b = 33'(PI_Q29);
      end
      S_X2: begin
        mul_a = 33'(x_q);
        mul_b = 33'(x_q);
      end
      S_TMUL: begin
        mul_a = 33'(mag_q);
        mul_b = 33'(x2_q);
      end
      S_TDIV: begin
        mul_a = ta_q;
        mul_b = term_recip(k_q);
      end
      S_GMUL: begin
        mul_a = 33'(res_q[26:0]);
        mul_b = 33'(cmag);
      end
      S_SCALE: begin
        if (cmd_q == CMD_UPDATE) begin
          mul_a = 33'(omag);
          mul_b = 33'(damp_q);
        end else begin
          mul_a = 33'(gmag_q);
          mul_b = 33'(nv_q);
        end
      end
      S_DRIVE: begin
        mul_a = 33'(gmag_q);
        mul_b = 33'(ds_q);
      end
      default: begin
        mul_a = 33'd0;
        mul_b = 33'd0;
      end
    endcase
  end

  // Loop counter
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == S_NORM || state_q == S_LOG || state_q == S_SQRT) begin
      cnt_d = cnt_last ? 5'd0 : cnt_q + 5'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 5'd0;
      k_q         <= 3'd0;
      seed_q      <= 31'd1;
      nv_q        <= 31'd16777216;
      damp_q      <= 32'h8000_0000;
      ds_q        <= 31'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_X2) begin
        k_q <= 3'd0;
      end else if (state_q == S_TFIX) begin
        k_q <= k_q + 3'd1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_RNG_SEED:       seed_q <= cfg_data_i[30:0];
          REG_NOISE_VARIANCE: nv_q   <= cfg_data_i[30:0];
          REG_DAMPING_FACTOR: damp_q <= cfg_data_i;
          REG_DRIVING_SCALE:  ds_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end else if (state_q == S_DRAW1 || state_q == S_DRAW2) begin
        seed_q <= pm_next;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q    <= in_data_i.command;
          idx_q    <= in_data_i.phase_index;
          inside_q <= 32'(in_data_i.phase_index) < 32'(PHASE_ENTRIES);
        end
      end
      S_DRAW1: begin
        y_q  <= uni;
        lz_q <= 5'd0;
      end
      S_DRAW2: u2_q <= uni;
      S_NORM: begin
        if (top_zero) begin
          y_q  <= y_q << shamt;
          lz_q <= lz_q + shamt;
        end
        f_q <= 24'd0;
      end
      S_LOG: begin
        if (sq[31]) begin
          y_q <= sq[31:1];
          f_q <= {f_q[22:0], 1'b1};
        end else begin
          y_q <= sq[30:0];
          f_q <= {f_q[22:0], 1'b0};
        end
      end
      S_LNMUL: begin
        v_q   <= 56'({prod[59:30], 24'd0});
        res_q <= 56'd0;
        bit_q <= 56'd1 << 54;
      end
      S_SQRT: begin
        if (take) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_XMUL: x_q <= prod[59:29];
      S_X2: begin
        x2_q  <= prod[61:30];
        mag_q <= 32'(ONE_Q30);
        sum_q <= 35'sd1073741824;
      end
      S_TMUL: ta_q <= prod[62:30];
      S_TDIV: q0_q <= prod[64:33];
      S_TFIX: begin
        mag_q <= term_q;
        if (k_q[0]) begin
          sum_q <= sum_q + $signed({3'b000, term_q});
        end else begin
          sum_q <= sum_q - $signed({3'b000, term_q});
        end
      end
      S_GMUL: begin
        gmag_q   <= prod[56:30];
        gneg_q   <= cneg;
        term_b_q <= 36'sd0;
      end
      S_SCALE: begin
        if (cmd_q == CMD_UPDATE) begin
          term_a_q <= oneg ? -$signed({3'b000, prod[63:31]})
                           :  $signed({3'b000, prod[63:31]});
        end else begin
          term_a_q <= gneg_q ? -$signed({2'b00, prod[57:24]})
                             :  $signed({2'b00, prod[57:24]});
        end
      end
      S_DRIVE: begin
        term_b_q <= gneg_q ? -$signed({2'b00, prod[57:24]})
                           :  $signed({2'b00, prod[57:24]});
      end
      S_DONE: begin
        if (out_free) begin
          out_q.phase_value     <= sat_val;
          out_q.phase_index_out <= idx_q;
        end
      end
      default: ;
    endcase
  end

  // Phase store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem[AW'(in_data_i.phase_index)];
    end
    if (state_q == S_DONE && out_free && inside_q) begin
      mem[AW'(idx_q)] <= sat_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_DRAW1)
    else $error("accepted item did not start the sequence");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("input not stalled while busy");

  a_fix_enough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TFIX |-> rem < 41'(2 * dvs))
    else $error("quotient estimate off by more than one");

  a_radius_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GMUL |-> res_q[55:27] == 29'd0)
    else $error("square root out of range");
`endif

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Ornstein-Uhlenbeck phase noise generator core.
// A class keeps its own copy of the generator, registers and phase memory,
// predicts every phase result from the accepted items and checks the results
// in order. Directed items cover the register extremes and the seed corner
// cases. Random phases then mix initialize and update chains under random
// input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ougn_pkg::*;

  localparam int unsigned N_ENTRIES = 1024;

  // Predicts phase values and holds the results still to come
  class ou_phase_predictor;
    logic [30:0] seed_reg;
    logic [30:0] variance_reg;
    logic [31:0] damping_reg;
    logic [30:0] drive_reg;
    logic [30:0] gen_state;
    logic [31:0] phase_mem [N_ENTRIES];
    out_item_t   pending_phases[$];
    int          errors;

    function new();
      seed_reg     = 31'd1;
      variance_reg = 31'd16777216;
      damping_reg  = 32'h8000_0000;
      drive_reg    = 31'd0;
      gen_state    = 31'd1;
      errors       = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_RNG_SEED: begin
          seed_reg  = data[30:0];
          gen_state = data[30:0];
        end
        REG_NOISE_VARIANCE: variance_reg = data[30:0];
        REG_DAMPING_FACTOR: damping_reg  = data;
        REG_DRIVING_SCALE:  drive_reg    = data[30:0];
        default: ;
      endcase
    endfunction

    // One minimal-standard step, clamped uniform in Q0.31
    function logic [30:0] next_uniform();
      longint unsigned s;
      s = gen_state;
      if (s == 0 || s >= PM_MOD) s = 1;
      s = (s * PM_MUL) % PM_MOD;
      gen_state = s[30:0];
      return (s < UNI_MAX) ? s[30:0] : UNI_MAX;
    endfunction

    // 2*ln(2^31/u) in Q8.24
    function longint unsigned neg_log2x(logic [30:0] u);
      int p;
      longint unsigned y, f, n;
      p = 0;
      f = 0;
      for (int i = 0; i < 31; i++) if (u[i]) p = i;
      y = longint'(u) << (30 - p);
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 30;
        f = f << 1;
        if (y >= 64'h8000_0000) begin
          y = y >> 1;
          f = f | 1;
        end
      end
      n = (longint'(31 - p) << 24) - f;
      return (n * LN2X2_Q30) >> 30;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // cos of u turns (Q0.31) in Q2.30
    function longint cos_turn_q30(logic [30:0] u);
      logic [1:0] q;
      longint unsigned r, x, x2, mag;
      longint sum;
      q   = u[30:29];
      r   = u[28:0];
      if (q[0]) r = QTR_TURN - r;
      x   = (r * PI_Q29) >> 29;
      x2  = (x * x) >> 30;
      mag = ONE_Q30;
      sum = ONE_Q30;
      for (int k = 0; k < 7; k++) begin
        mag = ((mag * x2) >> 30) / longint'((2 * k + 1) * (2 * k + 2));
        if (k % 2 == 0) sum = sum - longint'(mag);
        else sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = ONE_Q30;
      return (q == 2'd1 || q == 2'd2) ? -sum : sum;
    endfunction

    function void note_input(in_item_t item);
      logic [30:0] u1, u2;
      longint unsigned rad, gmag, omag;
      longint c, val, a, b;
      logic gneg, oneg;
      logic [31:0] old;
      out_item_t res;
      u1   = next_uniform();
      u2   = next_uniform();
      rad  = int_sqrt(neg_log2x(u1) << 24);
      c    = cos_turn_q30(u2);
      gneg = (c < 0);
      gmag = (rad * longint'(gneg ? -c : c)) >> 30;
      if (item.command == CMD_INIT) begin
        val = longint'((gmag * variance_reg) >> 24);
        if (gneg) val = -val;
      end else begin
        old  = phase_mem[item.phase_index];
        oneg = old[31];
        omag = oneg ? (64'h1_0000_0000 - old) : old;
        a    = longint'((omag * damping_reg) >> 31);
        if (oneg) a = -a;
        b    = longint'((gmag * drive_reg) >> 24);
        if (gneg) b = -b;
        val  = a + b;
      end
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      res.phase_value     = val[31:0];
      res.phase_index_out = item.phase_index;
      phase_mem[item.phase_index] = val[31:0];
      pending_phases = {pending_phases, res};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending_phases.size() == 0) begin
        $display("%0t: unexpected result value=%0d index=%0d", $time,
                 got.phase_value, got.phase_index_out);
        errors++;
        return;
      end
      exp_item = pending_phases.pop_front();
      if (got.phase_value !== exp_item.phase_value) begin
        $display("%0t: phase_value expected %0d actual %0d", $time,
                 exp_item.phase_value, got.phase_value);
        errors++;
      end
      if (got.phase_index_out !== exp_item.phase_index_out) begin
        $display("%0t: phase_index_out expected %0d actual %0d", $time,
                 exp_item.phase_index_out, got.phase_index_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  ou_phase_predictor phase_model = new();
  bit [N_ENTRIES-1:0] primed;
  bit gaps_on;
  bit stalls_on;
  int stall_left;

  ou_gaussian_noise_generator_core #(.PHASE_ENTRIES(N_ENTRIES)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Starts low so that the first rising edge comes after time zero
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Output stall pattern
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = idle_len();
    end
    out_stall_i <= (stall_left > 0);
  end

  // Monitors: accepted items and results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) phase_model.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) phase_model.check_result(out_data_o);
  end

  task automatic send_phase_cmd(logic cmd, logic [9:0] idx);
    int g;
    g = gaps_on ? idle_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_data_i  <= '{command: cmd, phase_index: idx};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_INIT) primed[idx] = 1'b1;
  endtask

  // Block must be idle; cfg_valid stays high across back-to-back writes
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    phase_model.write_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let every expected result come out, then allow for the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    while (phase_model.pending_phases.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick31(logic [31:0] hi);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'd0;
    if (r == 1) return hi;
    return $urandom() & hi;
  endfunction

  task automatic random_phase_cmd();
    logic [9:0] idx;
    idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                      : 10'($urandom_range(0, 31));
    if (!primed[idx] || $urandom_range(0, 3) == 0) send_phase_cmd(CMD_INIT, idx);
    else send_phase_cmd(CMD_UPDATE, idx);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    primed      = '0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    stall_left  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, both ends of the index range
    send_phase_cmd(CMD_INIT, 10'd0);
    send_phase_cmd(CMD_INIT, 10'd1023);
    send_phase_cmd(CMD_UPDATE, 10'd0);
    send_phase_cmd(CMD_UPDATE, 10'd1023);
    drain();

    // Seed of zero, maximum scales, damping above one, ignored indexes
    write_reg(REG_RNG_SEED, 32'd0);
    write_reg(REG_NOISE_VARIANCE, 32'h7FFF_FFFF);
    write_reg(REG_DAMPING_FACTOR, 32'hFFFF_FFFF);
    write_reg(REG_DRIVING_SCALE, 32'hFFFF_FFFF);
    write_reg(8'd4, 32'h1234_5678);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    end_writes();
    send_phase_cmd(CMD_INIT, 10'd5);
    repeat (3) send_phase_cmd(CMD_UPDATE, 10'd5);
    send_phase_cmd(CMD_UPDATE, 10'd0);
    send_phase_cmd(CMD_INIT, 10'h2AA);
    send_phase_cmd(CMD_INIT, 10'h155);
    send_phase_cmd(CMD_UPDATE, 10'h2AA);
    drain();

    // Seed of all ones, zero scales
    write_reg(REG_RNG_SEED, 32'hFFFF_FFFF);
    write_reg(REG_NOISE_VARIANCE, 32'd0);
    write_reg(REG_DAMPING_FACTOR, 32'd0);
    write_reg(REG_DRIVING_SCALE, 32'd0);
    end_writes();
    send_phase_cmd(CMD_INIT, 10'd7);
    send_phase_cmd(CMD_UPDATE, 10'd7);
    send_phase_cmd(CMD_UPDATE, 10'd1023);
    drain();

    // Seed with the unused top bit set, unit damping
    write_reg(REG_RNG_SEED, 32'h8000_0001);
    write_reg(REG_NOISE_VARIANCE, 32'h0100_0000);
    write_reg(REG_DAMPING_FACTOR, 32'h8000_0000);
    write_reg(REG_DRIVING_SCALE, 32'h0040_0000);
    end_writes();
    send_phase_cmd(CMD_INIT, 10'd9);
    repeat (4) send_phase_cmd(CMD_UPDATE, 10'd9);
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_RNG_SEED, ($urandom_range(0, 4) == 0) ? pick31(32'h7FFF_FFFF)
                                                          : $urandom());
      write_reg(REG_NOISE_VARIANCE, pick31(32'h7FFF_FFFF) >> $urandom_range(0, 7));
      case ($urandom_range(0, 4))
        0:       write_reg(REG_DAMPING_FACTOR, 32'h8000_0000);
        1:       write_reg(REG_DAMPING_FACTOR, $urandom());
        default: write_reg(REG_DAMPING_FACTOR, $urandom_range(32'h6000_0000, 32'h7FFF_FFFF));
      endcase
      write_reg(REG_DRIVING_SCALE, pick31(32'h7FFF_FFFF) >> $urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) write_reg(8'($urandom_range(4, 255)), $urandom());
      end_writes();
      gaps_on   = (ph != 1);
      stalls_on = (ph != 2);
      repeat (250) random_phase_cmd();
      drain();
    end

    if (phase_model.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
